// File: hdl/ldbf_pkg.sv
package ldbf_pkg;

   // Line geometry and edge list size.
   localparam int LINE_MAX   = 1024;
   localparam int EDGE_SLOTS = 4;

   localparam int ADDR_W = $clog2(LINE_MAX + 1);
   localparam int POS_W  = 10;
   localparam int SUM_W  = $clog2(LINE_MAX * 255 + 1);
   localparam int CNT_W  = $clog2(EDGE_SLOTS + 1);
   localparam int SLOT_W = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
   localparam int LIM_W  = 19;

   // Brightness coefficients in 16-bit fixed point and the gray limit.
   localparam logic [23:0] LUMA_R     = 24'd19595;
   localparam logic [23:0] LUMA_G     = 24'd38470;
   localparam logic [23:0] LUMA_B     = 24'd7471;
   localparam logic [19:0] GRAY_LIMIT = 20'd5400;

   // Side regions are 16 pixels wide.
   localparam int SIDE_LEN = 16;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes.
   localparam logic [1:0] CSR_EDGE_LEVEL = 2'd0;
   localparam logic [1:0] CSR_MIN_GAP    = 2'd1;
   localparam logic [1:0] CSR_MAX_GAP    = 2'd2;
   localparam logic [1:0] CSR_SIDE_LEVEL = 2'd3;

   typedef struct packed {
      logic [7:0]  edge_level;
      logic [9:0]  min_gap;
      logic [9:0]  max_gap;
      logic [7:0]  side_level;
   } ldbf_cfg_type;

   typedef struct packed {
      logic [7:0]  bright;
      logic        gray;
      logic        eol;
      logic [11:0] line_index;
   } ldbf_pix_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_SORT,
      ST_RD0,
      ST_RD1,
      ST_DIFF,
      ST_EVAL,
      ST_DONE
   } ldbf_state_type;

endpackage

// File: hdl/ldbf_front.sv
module ldbf_front import ldbf_pkg::*; (
   input  logic [7:0]   red,
   input  logic [7:0]   green,
   input  logic [7:0]   blue,
   input  logic         end_of_line,
   input  logic [11:0]  line_index,
   output ldbf_pix_type pix
);

   logic [23:0]        luma_sum;
   logic [9:0]         chan_sum;
   logic signed [10:0] dr, dg, db;
   logic signed [21:0] sq_r, sq_g, sq_b;
   logic [19:0]        spread;

   always_comb begin
      luma_sum = 24'(red) * LUMA_R + 24'(green) * LUMA_G + 24'(blue) * LUMA_B;
      chan_sum = 10'(red) + 10'(green) + 10'(blue);
      // Distance of each channel from the mean, scaled by three.
      dr = $signed(11'(10'(red) * 10'd3) - 11'(chan_sum));
      dg = $signed(11'(10'(green) * 10'd3) - 11'(chan_sum));
      db = $signed(11'(10'(blue) * 10'd3) - 11'(chan_sum));
      sq_r = dr * dr;
      sq_g = dg * dg;
      sq_b = db * db;
      spread = 20'(sq_r[17:0]) + 20'(sq_g[17:0]) + 20'(sq_b[17:0]);
      pix.bright     = luma_sum[23:16];
      pix.gray       = (spread < GRAY_LIMIT);
      pix.eol        = end_of_line;
      pix.line_index = line_index;
   end

endmodule

// File: hdl/ldbf_queue.sv
module ldbf_queue import ldbf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  ldbf_pix_type push_word,
   output logic         full,
   input  logic         pop,
   output ldbf_pix_type head_word,
   output logic         empty
);

   ldbf_pix_type      store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      head_word = store_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// File: hdl/ldbf_back.sv
module ldbf_back import ldbf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ldbf_cfg_type cfg,
   input  ldbf_pix_type q_word,
   input  logic         q_empty,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_found,
   output logic [9:0]   rsp_dark_start,
   output logic [9:0]   rsp_dark_end,
   output logic [11:0]  rsp_echo_index
);

   ldbf_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] pix_cnt_ff, pix_cnt_in;
   logic [SUM_W-1:0]  run_sum_ff, run_sum_in;
   logic [CNT_W-1:0]  fall_cnt_ff, fall_cnt_in;
   logic [CNT_W-1:0]  rise_cnt_ff, rise_cnt_in;
   logic [SLOT_W-1:0] wi_ff, wi_in;
   logic [SLOT_W-1:0] wj_ff, wj_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [7:0]        hist_bright_ff [4];
   logic              hist_gray_ff [4];
   logic [POS_W-1:0]  fall_pos_ff [EDGE_SLOTS];
   logic [7:0]        fall_mag_ff [EDGE_SLOTS];
   logic [POS_W-1:0]  rise_pos_ff [EDGE_SLOTS];
   logic [7:0]        rise_mag_ff [EDGE_SLOTS];
   logic [POS_W-1:0]  sfall_ff [EDGE_SLOTS];
   logic [POS_W-1:0]  srise_ff [EDGE_SLOTS];
   logic [SLOT_W-1:0] rank_f [EDGE_SLOTS];
   logic [SLOT_W-1:0] rank_r [EDGE_SLOTS];

   logic [SUM_W-1:0]  psum_mem [0:LINE_MAX];
   logic [ADDR_W-1:0] addr_a, addr_b;
   logic [SUM_W-1:0]  rd_a_ff, rd_b_ff;
   logic              rz_a_ff, rz_b_ff;
   logic [SUM_W-1:0]  pa, pb;

   logic              ok_ff;
   logic [LIM_W-1:0]  limit_ff;
   logic [SUM_W-1:0]  band_ff, pe1_ff, pf_ff, left_ff, right_ff;
   logic [SUM_W:0]    best_sum_ff;
   logic [POS_W-1:0]  best_f_ff, best_e_ff;
   logic [11:0]       echo_ff;
   logic              rsp_found_ff;
   logic [POS_W-1:0]  rsp_start_ff, rsp_end_ff;
   logic [11:0]       rsp_echo_ff;

   logic              proc, edge_on, fall_hit, rise_hit, can_load, last_i, last_j;
   logic [7:0]        fall_mag, rise_mag;
   logic [POS_W-1:0]  edge_pos, f_pos, e_pos, gap;
   logic [ADDR_W-1:0] e_ext, f_ext;
   logic              geo_ok;
   logic [LIM_W-1:0]  limit;
   logic [SUM_W-1:0]  side_th;
   logic [SUM_W:0]    pair_sum;
   logic              pass;

   // Strength ranks of the edge list entries.
   always_comb begin
      int acc_f;
      int acc_r;
      for (int k = 0; k < EDGE_SLOTS; k++) begin
         acc_f = 0;
         acc_r = 0;
         for (int m = 0; m < EDGE_SLOTS; m++) begin
            if (m != k && CNT_W'(m) < fall_cnt_ff &&
                (fall_mag_ff[m] > fall_mag_ff[k] ||
                 (fall_mag_ff[m] == fall_mag_ff[k] && fall_pos_ff[m] < fall_pos_ff[k]))) begin
               acc_f = acc_f + 1;
            end
            if (m != k && CNT_W'(m) < rise_cnt_ff &&
                (rise_mag_ff[m] > rise_mag_ff[k] ||
                 (rise_mag_ff[m] == rise_mag_ff[k] && rise_pos_ff[m] < rise_pos_ff[k]))) begin
               acc_r = acc_r + 1;
            end
         end
         rank_f[k] = SLOT_W'(acc_f);
         rank_r[k] = SLOT_W'(acc_r);
      end
   end

   always_comb begin
      q_pop    = (state_ff == ST_ACCUM) && !q_empty;
      proc     = q_pop && (pix_cnt_ff < ADDR_W'(LINE_MAX));
      edge_on  = proc && (pix_cnt_ff >= ADDR_W'(4)) && hist_gray_ff[1] && hist_gray_ff[3];
      fall_mag = hist_bright_ff[3] - hist_bright_ff[1];
      rise_mag = hist_bright_ff[1] - hist_bright_ff[3];
      fall_hit = edge_on && (hist_bright_ff[3] > hist_bright_ff[1]) &&
                 (fall_mag > cfg.edge_level);
      rise_hit = edge_on && (hist_bright_ff[1] > hist_bright_ff[3]) &&
                 (rise_mag > cfg.edge_level);
      edge_pos = pix_cnt_ff[POS_W-1:0] - POS_W'(3);

      f_pos  = sfall_ff[wi_ff];
      e_pos  = srise_ff[wj_ff];
      f_ext  = ADDR_W'(f_pos);
      e_ext  = ADDR_W'(e_pos);
      gap    = e_pos - f_pos;
      geo_ok = (e_pos > f_pos) && (e_ext + ADDR_W'(SIDE_LEN + 1) <= pix_cnt_ff) &&
               (f_ext >= ADDR_W'(SIDE_LEN)) && (gap > cfg.min_gap) && (gap < cfg.max_gap);
      limit  = LIM_W'(cfg.edge_level) * (LIM_W'(gap) + LIM_W'(1));

      addr_a = '0;
      addr_b = '0;
      if (state_ff == ST_RD0) begin
         addr_a = e_ext + ADDR_W'(1);
         addr_b = f_ext;
      end else if (state_ff == ST_RD1) begin
         addr_a = f_ext - ADDR_W'(SIDE_LEN);
         addr_b = e_ext + ADDR_W'(SIDE_LEN + 1);
      end
      pa = rz_a_ff ? '0 : rd_a_ff;
      pb = rz_b_ff ? '0 : rd_b_ff;

      side_th  = SUM_W'({cfg.side_level, 4'b0000});
      pair_sum = (SUM_W + 1)'(left_ff) + (SUM_W + 1)'(right_ff);
      pass     = ok_ff && ((LIM_W'(band_ff)) < limit_ff) &&
                 (left_ff >= side_th) && (right_ff >= side_th);
      last_i   = (CNT_W'(wi_ff) + CNT_W'(1) >= fall_cnt_ff);
      last_j   = (CNT_W'(wj_ff) + CNT_W'(1) >= rise_cnt_ff);
      can_load = !rsp_valid_ff || !rsp_stall;
   end

   // Sequencer: accumulate the line, rank the edges, then walk all pairs.
   always_comb begin
      state_in     = state_ff;
      pix_cnt_in   = pix_cnt_ff;
      run_sum_in   = run_sum_ff;
      fall_cnt_in  = fall_cnt_ff;
      rise_cnt_in  = rise_cnt_ff;
      wi_in        = wi_ff;
      wj_in        = wj_ff;
      found_in     = found_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (proc) begin
               pix_cnt_in = pix_cnt_ff + ADDR_W'(1);
               run_sum_in = run_sum_ff + SUM_W'(q_word.bright);
               if (fall_hit && fall_cnt_ff < CNT_W'(EDGE_SLOTS)) begin
                  fall_cnt_in = fall_cnt_ff + CNT_W'(1);
               end
               if (rise_hit && rise_cnt_ff < CNT_W'(EDGE_SLOTS)) begin
                  rise_cnt_in = rise_cnt_ff + CNT_W'(1);
               end
            end
            if (q_pop && q_word.eol) begin
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            found_in = 1'b0;
            wi_in    = '0;
            wj_in    = '0;
            if (fall_cnt_ff == '0 || rise_cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RD0;
            end
         end
         ST_RD0: state_in = ST_RD1;
         ST_RD1: state_in = ST_DIFF;
         ST_DIFF: state_in = ST_EVAL;
         ST_EVAL: begin
            if (pass) begin
               found_in = 1'b1;
            end
            if (!last_j) begin
               wj_in    = wj_ff + SLOT_W'(1);
               state_in = ST_RD0;
            end else if (!last_i) begin
               wj_in    = '0;
               wi_in    = wi_ff + SLOT_W'(1);
               state_in = ST_RD0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               pix_cnt_in   = '0;
               run_sum_in   = '0;
               fall_cnt_in  = '0;
               rise_cnt_in  = '0;
               state_in     = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         pix_cnt_ff   <= '0;
         run_sum_ff   <= '0;
         fall_cnt_ff  <= '0;
         rise_cnt_ff  <= '0;
         wi_ff        <= '0;
         wj_ff        <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pix_cnt_ff   <= pix_cnt_in;
         run_sum_ff   <= run_sum_in;
         fall_cnt_ff  <= fall_cnt_in;
         rise_cnt_ff  <= rise_cnt_in;
         wi_ff        <= wi_in;
         wj_ff        <= wj_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Brightness history and edge lists.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            hist_bright_ff[k] <= '0;
            hist_gray_ff[k]   <= 1'b0;
         end
         for (int k = 0; k < EDGE_SLOTS; k++) begin
            fall_pos_ff[k] <= '0;
            fall_mag_ff[k] <= '0;
            rise_pos_ff[k] <= '0;
            rise_mag_ff[k] <= '0;
         end
      end else if (proc) begin
         hist_bright_ff[0] <= q_word.bright;
         hist_gray_ff[0]   <= q_word.gray;
         for (int k = 1; k < 4; k++) begin
            hist_bright_ff[k] <= hist_bright_ff[k-1];
            hist_gray_ff[k]   <= hist_gray_ff[k-1];
         end
         if (fall_hit) begin
            if (fall_cnt_ff < CNT_W'(EDGE_SLOTS)) begin
               fall_pos_ff[fall_cnt_ff[SLOT_W-1:0]] <= edge_pos;
               fall_mag_ff[fall_cnt_ff[SLOT_W-1:0]] <= fall_mag;
            end else if (fall_mag > fall_mag_ff[EDGE_SLOTS-1]) begin
               fall_pos_ff[EDGE_SLOTS-1] <= edge_pos;
               fall_mag_ff[EDGE_SLOTS-1] <= fall_mag;
            end
         end
         if (rise_hit) begin
            if (rise_cnt_ff < CNT_W'(EDGE_SLOTS)) begin
               rise_pos_ff[rise_cnt_ff[SLOT_W-1:0]] <= edge_pos;
               rise_mag_ff[rise_cnt_ff[SLOT_W-1:0]] <= rise_mag;
            end else if (rise_mag > rise_mag_ff[EDGE_SLOTS-1]) begin
               rise_pos_ff[EDGE_SLOTS-1] <= edge_pos;
               rise_mag_ff[EDGE_SLOTS-1] <= rise_mag;
            end
         end
      end
   end

   // Prefix sum memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (proc) begin
         psum_mem[pix_cnt_ff + ADDR_W'(1)] <= run_sum_ff + SUM_W'(q_word.bright);
      end
      rd_a_ff <= psum_mem[addr_a];
      rd_b_ff <= psum_mem[addr_b];
      rz_a_ff <= (addr_a == '0) || (addr_a > ADDR_W'(LINE_MAX));
      rz_b_ff <= (addr_b == '0) || (addr_b > ADDR_W'(LINE_MAX));
   end

   // Pair walk datapath and result registers.
   always_ff @(posedge clock) begin
      if (q_pop && q_word.eol) begin
         echo_ff <= q_word.line_index;
      end
      if (state_ff == ST_SORT) begin
         for (int k = 0; k < EDGE_SLOTS; k++) begin
            if (CNT_W'(k) < fall_cnt_ff) begin
               sfall_ff[rank_f[k]] <= fall_pos_ff[k];
            end
            if (CNT_W'(k) < rise_cnt_ff) begin
               srise_ff[rank_r[k]] <= rise_pos_ff[k];
            end
         end
         best_sum_ff <= '0;
         best_f_ff   <= '0;
         best_e_ff   <= '0;
      end
      if (state_ff == ST_RD0) begin
         ok_ff    <= geo_ok;
         limit_ff <= limit;
      end
      if (state_ff == ST_RD1) begin
         band_ff <= pa - pb;
         pe1_ff  <= pa;
         pf_ff   <= pb;
      end
      if (state_ff == ST_DIFF) begin
         left_ff  <= pf_ff - pa;
         right_ff <= pb - pe1_ff;
      end
      if (state_ff == ST_EVAL && pass && (!found_ff || pair_sum > best_sum_ff)) begin
         best_sum_ff <= pair_sum;
         best_f_ff   <= f_pos;
         best_e_ff   <= e_pos;
      end
      if (state_ff == ST_DONE && can_load) begin
         rsp_found_ff <= found_ff;
         rsp_start_ff <= best_f_ff;
         rsp_end_ff   <= best_e_ff;
         rsp_echo_ff  <= echo_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_dark_start = rsp_start_ff;
   assign rsp_dark_end   = rsp_end_ff;
   assign rsp_echo_index = rsp_echo_ff;

endmodule

// File: hdl/line_dark_band_finder_core.sv
// A pixel word is held in the queue until the back part takes it; after the end-of-line word
// is taken, the back part ranks the kept edges (F, R: at most 4 each) and walks the F*R pairs.
// One pixel word is taken per cycle while the queue has room; during the end-of-line pairing
// walk a 4-word queue takes the first words of the next line; words stall when it is full.
// Reset is synchronous and active high; control and configuration registers return to defaults.
module line_dark_band_finder_core import ldbf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_end_of_line,
   input  logic [11:0] req_line_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [9:0]  rsp_dark_start,
   output logic [9:0]  rsp_dark_end,
   output logic [11:0] rsp_echo_index,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);

   // The front part turns each pixel into a brightness and a gray flag. The back part
   // keeps running prefix sums in a memory, collects falling and rising edges (a full list
   // replaces its last entry with a stronger edge), and at the end of a line ranks them and
   // walks every falling/rising pair in four states, reading the prefix sums through two read ports.

   ldbf_cfg_type cfg_ff;
   ldbf_pix_type pix_word;
   ldbf_pix_type head_word;
   logic         q_full, q_empty, q_pop, push;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.edge_level <= 8'd70;
         cfg_ff.min_gap    <= 10'd10;
         cfg_ff.max_gap    <= 10'd50;
         cfg_ff.side_level <= 8'd200;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_EDGE_LEVEL: cfg_ff.edge_level <= csr_data[7:0];
            CSR_MIN_GAP:    cfg_ff.min_gap    <= csr_data;
            CSR_MAX_GAP:    cfg_ff.max_gap    <= csr_data;
            CSR_SIDE_LEVEL: cfg_ff.side_level <= csr_data[7:0];
            default:        cfg_ff <= cfg_ff;
         endcase
      end
   end

   // A word is taken whenever the queue has room.
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   ldbf_front u_front (
      .red         (req_red),
      .green       (req_green),
      .blue        (req_blue),
      .end_of_line (req_end_of_line),
      .line_index  (req_line_index),
      .pix         (pix_word)
   );

   ldbf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (pix_word),
      .full      (q_full),
      .pop       (q_pop),
      .head_word (head_word),
      .empty     (q_empty)
   );

   ldbf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_word         (head_word),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_dark_start (rsp_dark_start),
      .rsp_dark_end   (rsp_dark_end),
      .rsp_echo_index (rsp_echo_index)
   );

endmodule
